FILE: hw/rtl/bsr_pkg.sv
package bsr_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;

  localparam int COUNT_W = 11;
  localparam int TOL_W   = 31;
  localparam int POS_W   = 10;
  localparam int VALUE_W = 32;
  localparam int INDEX_W = 10;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 31;

  localparam int S_TDATA_W = 80;
  localparam int M_TDATA_W = 16;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_COUNT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_TOL    = 1'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_COMPARE,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic table_write;
    logic start;
    logic go_right;
    logic go_left;
    logic mark_hit;
    logic result_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic range_empty;
    logic below;
    logic above;
    logic write_ok;
  } sts_t;

endpackage

FILE: hw/rtl/bsr_ram.sv
module bsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/bsr_ctrl.sv
module bsr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  input  logic          req_type,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  output bsr_pkg::cmd_t cmd,
  input  bsr_pkg::sts_t sts
);

  bsr_pkg::state_t state, state_next;
  logic            out_valid, out_valid_next;
  logic            accept;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == bsr_pkg::ST_IDLE);
  assign m_tvalid = out_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      bsr_pkg::ST_IDLE: begin
        if (accept && req_type == bsr_pkg::REQ_SEARCH) begin
          state_next = bsr_pkg::ST_PROBE;
        end
      end
      bsr_pkg::ST_PROBE: begin
        if (sts.range_empty) begin
          state_next = bsr_pkg::ST_FINISH;
        end else begin
          state_next = bsr_pkg::ST_COMPARE;
        end
      end
      bsr_pkg::ST_COMPARE: begin
        if (sts.below || sts.above) begin
          state_next = bsr_pkg::ST_PROBE;
        end else begin
          state_next = bsr_pkg::ST_FINISH;
        end
      end
      bsr_pkg::ST_FINISH: begin
        if (!out_valid || m_tready) begin
          state_next = bsr_pkg::ST_IDLE;
        end
      end
      default: state_next = bsr_pkg::ST_IDLE;
    endcase
  end

  // The table read address follows the search bounds, so a probe needs no command.
  always_comb begin
    cmd = '0;
    unique case (state)
      bsr_pkg::ST_IDLE: begin
        cmd.table_write = accept && req_type == bsr_pkg::REQ_WRITE && sts.write_ok;
        cmd.start       = accept && req_type == bsr_pkg::REQ_SEARCH;
      end
      bsr_pkg::ST_PROBE: ;
      bsr_pkg::ST_COMPARE: begin
        cmd.go_right = sts.below;
        cmd.go_left  = sts.above && !sts.below;
        cmd.mark_hit = !sts.below && !sts.above;
      end
      bsr_pkg::ST_FINISH: begin
        cmd.result_load = !out_valid || m_tready;
      end
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.result_load) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bsr_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: hw/rtl/bsr_dp.sv
module bsr_dp #(
  parameter int TABLE_DEPTH = bsr_pkg::TABLE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [bsr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bsr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [bsr_pkg::POS_W-1:0]          entry_position,
  input  logic signed [bsr_pkg::VALUE_W-1:0] entry_value,
  input  logic signed [bsr_pkg::VALUE_W-1:0] search_key,
  input  bsr_pkg::cmd_t                      cmd,
  output bsr_pkg::sts_t                      sts,
  output logic                               found,
  output logic [bsr_pkg::INDEX_W-1:0]        match_index
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [bsr_pkg::COUNT_W-1:0]      active_count;
  logic [bsr_pkg::TOL_W-1:0]        match_tolerance;
  logic signed [bsr_pkg::VALUE_W-1:0] key;
  logic [CW-1:0]                    lo, hi_ex;
  logic [CW-1:0]                    count;
  logic [CW:0]                      mid_sum;
  logic [AW-1:0]                    mid;
  logic [bsr_pkg::VALUE_W-1:0]      rdata;
  logic signed [bsr_pkg::VALUE_W:0] diff, tol_pos, tol_neg;
  logic                             hit;
  logic [bsr_pkg::INDEX_W-1:0]      hit_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_count    <= '0;
      match_tolerance <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bsr_pkg::CFG_ACTIVE_COUNT: active_count    <= cfg_data[bsr_pkg::COUNT_W-1:0];
        bsr_pkg::CFG_MATCH_TOL:    match_tolerance <= cfg_data[bsr_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Counts beyond the table size search the whole table.
  always_comb begin
    if (32'(active_count) > 32'(TABLE_DEPTH)) begin
      count = CW'(TABLE_DEPTH);
    end else begin
      count = CW'(active_count);
    end
  end

  // The live range is [lo, hi_ex); the probe is floor((lo + hi_ex - 1) / 2).
  assign mid_sum = {1'b0, lo} + {1'b0, hi_ex} - (CW + 1)'(1);
  assign mid     = AW'(mid_sum >> 1);

  assign tol_pos = $signed({2'b00, match_tolerance});
  assign tol_neg = -tol_pos;
  assign diff    = $signed({rdata[bsr_pkg::VALUE_W-1], rdata}) -
                   $signed({key[bsr_pkg::VALUE_W-1], key});

  assign sts.range_empty = (lo >= hi_ex);
  assign sts.below       = (diff < tol_neg);
  assign sts.above       = (diff > tol_pos);
  assign sts.write_ok    = (32'(entry_position) < 32'(TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key       <= search_key;
      lo        <= '0;
      hi_ex     <= count;
      hit       <= 1'b0;
      hit_index <= '0;
    end else begin
      if (cmd.go_right) begin
        lo <= CW'(mid) + CW'(1);
      end
      if (cmd.go_left) begin
        hi_ex <= CW'(mid);
      end
      if (cmd.mark_hit) begin
        hit       <= 1'b1;
        hit_index <= bsr_pkg::INDEX_W'(mid);
      end
    end
    if (cmd.result_load) begin
      found       <= hit;
      match_index <= hit_index;
    end
  end

  bsr_ram #(
    .WIDTH(bsr_pkg::VALUE_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (cmd.table_write),
    .waddr(AW'(entry_position)),
    .wdata(entry_value),
    .raddr(mid),
    .rdata(rdata)
  );

endmodule

FILE: hw/rtl/sorted_table_binary_search_core.sv
// Sorted-table binary search over signed Q16.16 values.
// Input stream (s_*): s_tuser selects the request, 0 writes a table entry and
// 1 searches for a key. A write stores s_tdata's value at its position in the
// same cycle it is accepted and produces no output transaction. A search
// produces exactly one output transaction on m_*: m_tuser is the found flag
// and m_tdata carries the matching position (0 when nothing matched).
// Configuration: cfg_we writes cfg_data to register cfg_index (0 = active
// entry count, 1 = match tolerance); write only while no search is running.
// Search length: a search over n active entries probes at most floor(log2(n))
// + 1 entries. Each probe passes through a PROBE state for the registered
// table read and a COMPARE state for the compare. Writes are taken one per
// cycle while no search is running.
// One request is in flight at a time; s_tready is low while a search runs.
// The result sits in an output register; if the receiver stalls, the next
// search runs to completion and then waits until that register frees up.
// Reset clears the configuration registers and the handshake state; search and
// result registers and table contents are undefined until loaded or written.
module sorted_table_binary_search_core #(
  parameter int TABLE_DEPTH = bsr_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bsr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bsr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [9:0] entry_position, [41:10] entry_value, [73:42] search_key
  input  logic [bsr_pkg::S_TDATA_W-1:0]   s_tdata,
  // [0] req_type
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [9:0] match_index
  output logic [bsr_pkg::M_TDATA_W-1:0]   m_tdata,
  // [0] found
  output logic                            m_tuser
);

  bsr_pkg::cmd_t               cmd;
  bsr_pkg::sts_t               sts;
  logic [bsr_pkg::INDEX_W-1:0] match_index;

  bsr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .req_type(s_tuser),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cmd     (cmd),
    .sts     (sts)
  );

  bsr_dp #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .entry_position(s_tdata[9:0]),
    .entry_value   (s_tdata[41:10]),
    .search_key    (s_tdata[73:42]),
    .cmd           (cmd),
    .sts           (sts),
    .found         (m_tuser),
    .match_index   (match_index)
  );

  assign m_tdata = {{(bsr_pkg::M_TDATA_W - bsr_pkg::INDEX_W){1'b0}}, match_index};

endmodule
